// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the tour permutation table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define TPT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication built on the macro above.
`define TPT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	`TPT_ASSERT(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

// ===== rtl/tpt_pkg.sv =====
// Shared constants, item types, action codes, controller states and the
// command/status structs of the tour permutation table. No dependencies.
package tpt_pkg;

	localparam int MAX_CITIES     = 64;
	localparam int CITY_W         = $clog2(MAX_CITIES);
	localparam int SIZE_W         = $clog2(MAX_CITIES + 1);
	localparam int ACT_W          = 3;
	localparam int POS_W          = 7;
	localparam int DIST_IN_W      = 32;
	localparam int LEN_W          = 38;
	localparam int DIST_WIDTH_DEF = 32;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef logic [SIZE_W-1:0] size_t;

	typedef enum logic [ACT_W-1:0] {
		OP_SET     = 3'd0,
		OP_SWAP    = 3'd1,
		OP_RD_CITY = 3'd2,
		OP_RD_POS  = 3'd3,
		OP_LOAD    = 3'd4,
		OP_LENGTH  = 3'd5,
		OP_XFORM   = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SWAP_W1,
		ST_SWAP_W2,
		ST_SWAP_W3,
		ST_LEN,
		ST_LEN_DRAIN,
		ST_WALK,
		ST_COPY,
		ST_RESULT
	} st_t;

	typedef struct packed {
		logic [ACT_W-1:0]     action;
		logic [POS_W-1:0]     position_a;
		logic [POS_W-1:0]     position_b;
		logic [POS_W-1:0]     city;
		logic [CITY_W-1:0]    from_city;
		logic [CITY_W-1:0]    to_city;
		logic [DIST_IN_W-1:0] distance;
	} tpt_in_t;

	typedef struct packed {
		logic [CITY_W-1:0] city_out;
		logic [CITY_W-1:0] position_out;
		logic [LEN_W-1:0]  tour_length;
		logic              status;
	} tpt_out_t;

	// Controller to datapath: one strobe per micro-operation plus the step index.
	typedef struct packed {
		logic              capture;
		logic              set_wr;
		logic              swap_rd;
		logic              swap_w1;
		logic              swap_w2;
		logic              swap_w3;
		logic              rd_city;
		logic              rd_pos;
		logic              load_wr;
		logic              len_clr;
		logic              len_issue;
		logic              walk_rd;
		logic              walk_wr;
		logic              copy_rd;
		logic              copy_wr;
		logic              out_load;
		logic [CITY_W-1:0] idx;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [ACT_W-1:0] op;
		logic             ok;
		size_t            size;
		logic             len_busy;
		logic             out_free;
	} dp_stat_t;

endpackage

// ===== rtl/tpt_chan_if.sv =====
// Valid/ready channel carrying one payload item of a chosen type.
// Used for the request, result and size-write channels; no dependencies.
interface tpt_chan_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/tour_permutation_table.sv =====
// Top level of the tour permutation table: controller plus datapath.
// Depends on tpt_pkg, tpt_chan_if, tpt_ctrl and tpt_dp.
//
//   channel | role   | payload      | accepted when
//   --------+--------+--------------+-----------------------
//   req     | sink   | tpt_in_t     | req.valid && req.ready
//   rsp     | source | tpt_out_t    | rsp.valid && rsp.ready
//   cfg     | sink   | size_t       | cfg.valid && cfg.ready
//
// Each item is taken in the idle state; no new item is accepted until the
// block is back in idle. Set, read city, read position and load distance
// pass through decode and result; swap makes two writes to each table through
// one write port; length sends each position's city pair through the
// city-then-distance read pipeline and drains it; transform walks the tour,
// then copies it back. Reset clears control, the size (64) and the length
// sum; the tables need no clearing pass. A stalled result holds the block in
// its result state; the next item is taken once the result register has room.
module tour_permutation_table #(
	parameter int DIST_WIDTH = tpt_pkg::DIST_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	tpt_chan_if.sink   req,
	tpt_chan_if.source rsp,
	tpt_chan_if.sink   cfg
);
	import tpt_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// size writes are taken in any cycle; the user keeps them to idle time
	assign cfg.ready = 1'b1;

	// sequence each action as micro-operations
	tpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// tables, length pipeline and result register
	tpt_dp #(
		.DIST_WIDTH (DIST_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.in_item   (req.payload),
		.cfg_valid (cfg.valid),
		.cfg_size  (cfg.payload),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_item  (rsp.payload)
	);

endmodule

// ===== rtl/tpt_ctrl.sv =====
// Controller of the tour permutation table: sequences each action as strobes
// to the datapath. Depends on tpt_pkg.
module tpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tpt_pkg::dp_stat_t stat,
	output tpt_pkg::dp_cmd_t  cmd
);
	import tpt_pkg::*;

	st_t               state_q, state_d;
	logic [SIZE_W-1:0] cnt_q, cnt_d;
	logic              last_len;
	logic              last_step;

	assign last_len  = (cnt_q == stat.size - SIZE_W'(1));
	assign last_step = (cnt_q == stat.size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cnt_d = '0;
				if (!stat.ok) begin
					state_d = ST_RESULT;
				end else begin
					unique case (stat.op)
						OP_SWAP:   state_d = ST_SWAP_W1;
						OP_LENGTH: state_d = ST_LEN;
						OP_XFORM:  state_d = ST_WALK;
						default:   state_d = ST_RESULT;
					endcase
				end
			end
			ST_SWAP_W1: state_d = ST_SWAP_W2;
			ST_SWAP_W2: state_d = ST_SWAP_W3;
			ST_SWAP_W3: state_d = ST_RESULT;
			ST_LEN: begin
				if (last_len) begin
					state_d = ST_LEN_DRAIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SIZE_W'(1);
				end
			end
			ST_LEN_DRAIN: begin
				if (!stat.len_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_WALK: begin
				if (last_step) begin
					state_d = ST_COPY;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SIZE_W'(1);
				end
			end
			ST_COPY: begin
				if (last_step) begin
					state_d = ST_RESULT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + SIZE_W'(1);
				end
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.idx  = cnt_q[CITY_W-1:0];
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: cmd.capture = in_valid;
			ST_DECODE: begin
				if (stat.ok) begin
					unique case (stat.op)
						OP_SET:     cmd.set_wr  = 1'b1;
						OP_SWAP:    cmd.swap_rd = 1'b1;
						OP_RD_CITY: cmd.rd_city = 1'b1;
						OP_RD_POS:  cmd.rd_pos  = 1'b1;
						OP_LOAD:    cmd.load_wr = 1'b1;
						OP_LENGTH:  cmd.len_clr = 1'b1;
						default:    ;
					endcase
				end
			end
			ST_SWAP_W1:   cmd.swap_w1   = 1'b1;
			ST_SWAP_W2:   cmd.swap_w2   = 1'b1;
			ST_SWAP_W3:   cmd.swap_w3   = 1'b1;
			ST_LEN:       cmd.len_issue = 1'b1;
			ST_LEN_DRAIN: ;
			ST_WALK: begin
				// read step k while writing the city fetched at step k-1
				cmd.walk_rd = !last_step;
				cmd.walk_wr = (cnt_q != '0);
			end
			ST_COPY: begin
				cmd.copy_rd = !last_step;
				cmd.copy_wr = (cnt_q != '0);
			end
			ST_RESULT: cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ===== rtl/tpt_dp.sv =====
// Datapath of the tour permutation table: size register, request register,
// the four tables, the length pipeline and the result register. Uses tpt_pkg.
module tpt_dp #(
	parameter int DIST_WIDTH = tpt_pkg::DIST_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpt_pkg::dp_cmd_t  cmd,
	output tpt_pkg::dp_stat_t stat,
	input  tpt_pkg::tpt_in_t  in_item,
	input  logic              cfg_valid,
	input  tpt_pkg::size_t    cfg_size,
	input  logic              out_ready,
	output logic              out_valid,
	output tpt_pkg::tpt_out_t out_item
);
	import tpt_pkg::*;

	localparam int DIST_DEPTH = MAX_CITIES * MAX_CITIES;
	localparam int DADDR_W    = $clog2(DIST_DEPTH);
	localparam int SUM_W      = ((DIST_WIDTH > LEN_W) ? DIST_WIDTH : LEN_W) + 1;

	size_t   size_q;
	tpt_in_t req_q;

	logic [CITY_W-1:0]     cap_mem [MAX_CITIES];
	logic [CITY_W-1:0]     poc_mem [MAX_CITIES];
	logic [CITY_W-1:0]     scr_mem [MAX_CITIES];
	logic [DIST_WIDTH-1:0] dist_mem [DIST_DEPTH];

	logic [CITY_W-1:0]     cap_rd_a_q, cap_rd_b_q, poc_rd_a_q, poc_rd_b_q, scr_rd_q;
	logic [DIST_WIDTH-1:0] dist_rd_s2;
	logic                  len_v_s1, len_v_s2;
	logic [LEN_W-1:0]      acc_q, acc_d;
	logic [SUM_W-1:0]      len_sum;

	logic [CITY_W-1:0] pa, pb, cty, wr_idx, len_nxt;
	logic              ok;

	logic              cap_we, cap_re_a, cap_re_b;
	logic [CITY_W-1:0] cap_wa, cap_wd, cap_ra_a, cap_ra_b;
	logic              poc_we, poc_re_a, poc_re_b;
	logic [CITY_W-1:0] poc_wa, poc_wd, poc_ra_a, poc_ra_b;

	logic       out_valid_q;
	tpt_out_t   out_q;

	assign pa     = req_q.position_a[CITY_W-1:0];
	assign pb     = req_q.position_b[CITY_W-1:0];
	assign cty    = req_q.city[CITY_W-1:0];
	assign wr_idx = cmd.idx - CITY_W'(1);
	assign len_nxt = ((SIZE_W'(cmd.idx) + SIZE_W'(1)) == size_q) ? '0 : cmd.idx + CITY_W'(1);

	// tour size: ignore writes outside 1..MAX_CITIES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(MAX_CITIES);
		end else if (cfg_valid && cfg_size != '0 && cfg_size <= SIZE_W'(MAX_CITIES)) begin
			size_q <= cfg_size;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_item;
		end
	end

	always_comb begin
		unique case (req_q.action) inside
			OP_SET:     ok = (SIZE_W'(req_q.position_a) < size_q) && (SIZE_W'(req_q.city) < size_q);
			OP_SWAP:    ok = (SIZE_W'(req_q.position_a) < size_q)
			                 && (SIZE_W'(req_q.position_b) < size_q);
			OP_RD_CITY: ok = (SIZE_W'(req_q.position_a) <= size_q);
			OP_RD_POS:  ok = (SIZE_W'(req_q.city) < size_q);
			OP_LOAD, OP_LENGTH, OP_XFORM: ok = 1'b1;
			default:    ok = 1'b0;
		endcase
	end

	// city_at_position ports
	always_comb begin
		cap_we = 1'b1;
		cap_wa = pa;
		cap_wd = cty;
		if (cmd.set_wr) begin
			cap_wa = pa;
			cap_wd = cty;
		end else if (cmd.swap_w1) begin
			cap_wa = pa;
			cap_wd = cap_rd_b_q;
		end else if (cmd.swap_w2) begin
			cap_wa = pb;
			cap_wd = cap_rd_a_q;
		end else if (cmd.copy_wr) begin
			cap_wa = wr_idx;
			cap_wd = scr_rd_q;
		end else begin
			cap_we = 1'b0;
		end

		cap_re_a = cmd.swap_rd | cmd.rd_city | cmd.len_issue | cmd.walk_rd;
		if (cmd.swap_rd) begin
			cap_ra_a = pa;
		end else if (cmd.rd_city) begin
			// the position one past the end wraps to the start
			cap_ra_a = (SIZE_W'(req_q.position_a) == size_q) ? '0 : pa;
		end else if (cmd.len_issue) begin
			cap_ra_a = cmd.idx;
		end else begin
			// follow the successor fetched last step; start at position zero
			cap_ra_a = cmd.walk_wr ? cap_rd_a_q : '0;
		end

		cap_re_b = cmd.swap_rd | cmd.len_issue;
		cap_ra_b = cmd.swap_rd ? pb : len_nxt;
	end

	// position_of_city ports
	always_comb begin
		poc_we = 1'b1;
		poc_wa = cty;
		poc_wd = pa;
		if (cmd.set_wr) begin
			poc_wa = cty;
			poc_wd = pa;
		end else if (cmd.swap_w2) begin
			poc_wa = cap_rd_a_q;
			poc_wd = poc_rd_b_q;
		end else if (cmd.swap_w3) begin
			poc_wa = cap_rd_b_q;
			poc_wd = poc_rd_a_q;
		end else if (cmd.copy_wr) begin
			poc_wa = scr_rd_q;
			poc_wd = wr_idx;
		end else begin
			poc_we = 1'b0;
		end

		poc_re_a = cmd.swap_w1 | cmd.rd_pos;
		poc_ra_a = cmd.swap_w1 ? cap_rd_a_q : cty;
		poc_re_b = cmd.swap_w1;
		poc_ra_b = cap_rd_b_q;
	end

	always_ff @(posedge clk) begin
		if (cap_we) begin
			cap_mem[cap_wa] <= cap_wd;
		end
		if (cap_re_a) begin
			cap_rd_a_q <= cap_mem[cap_ra_a];
		end
		if (cap_re_b) begin
			cap_rd_b_q <= cap_mem[cap_ra_b];
		end
	end

	always_ff @(posedge clk) begin
		if (poc_we) begin
			poc_mem[poc_wa] <= poc_wd;
		end
		if (poc_re_a) begin
			poc_rd_a_q <= poc_mem[poc_ra_a];
		end
		if (poc_re_b) begin
			poc_rd_b_q <= poc_mem[poc_ra_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_wr) begin
			scr_mem[wr_idx] <= cap_rd_a_q;
		end
		if (cmd.copy_rd) begin
			scr_rd_q <= scr_mem[cmd.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			dist_mem[{req_q.from_city, req_q.to_city}] <= DIST_WIDTH'(req_q.distance);
		end
		if (len_v_s1) begin
			dist_rd_s2 <= dist_mem[DADDR_W'({cap_rd_a_q, cap_rd_b_q})];
		end
	end

	// length pipeline: city pair read, distance read, saturating add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_v_s1 <= 1'b0;
			len_v_s2 <= 1'b0;
		end else begin
			len_v_s1 <= cmd.len_issue;
			len_v_s2 <= len_v_s1;
		end
	end

	assign len_sum = SUM_W'(acc_q) + SUM_W'(dist_rd_s2);
	assign acc_d   = (len_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.len_clr) begin
			acc_q <= '0;
		end else if (len_v_s2) begin
			acc_q <= acc_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.city_out     <= (ok && req_q.action == OP_RD_CITY) ? cap_rd_a_q : '0;
			out_q.position_out <= (ok && req_q.action == OP_RD_POS) ? poc_rd_a_q : '0;
			out_q.tour_length  <= (req_q.action == OP_LENGTH) ? acc_q : '0;
			out_q.status       <= !ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign stat.op       = req_q.action;
	assign stat.ok       = ok;
	assign stat.size     = size_q;
	assign stat.len_busy = len_v_s1 | len_v_s2;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/tpt_checker.sv =====
// Port-level checks for the tour permutation table, bound to the top level.
// Depends on tpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tpt_pkg::tpt_out_t rsp_item
);
	import tpt_pkg::*;

	// one item in work at a time: no acceptance in the cycle after one
	`TPT_ASSERT_NEXT(a_one_in_work, clk, arst_n, req_valid && req_ready, !req_ready, "item accepted twice in a row")

	`TPT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// a rejected action carries no answer
	`TPT_ASSERT(a_err_clean, clk, arst_n, rsp_valid && rsp_item.status |-> (rsp_item.city_out == '0) && (rsp_item.position_out == '0) && (rsp_item.tour_length == '0), "error result with answer fields set")

	// a length answer excludes the lookup answers
	`TPT_ASSERT(a_len_alone, clk, arst_n, rsp_valid && (rsp_item.tour_length != '0) |-> (rsp_item.city_out == '0) && (rsp_item.position_out == '0), "length mixed with lookup result")

endmodule

bind tour_permutation_table tpt_checker u_tpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_item  (rsp.payload)
);
